### hdl/jlh_pkg.sv
// ----------------------------------------------------------------------------
// jlh_pkg
// Shared types and constants for the lookup2 byte-stream hash: the three-word
// mixing state and one line of the lookup2 mix.
// ----------------------------------------------------------------------------
package jlh_pkg;

    localparam logic [31:0] GOLDEN     = 32'h9e37_79b9;
    localparam int          MIX_LINES  = 9;
    localparam int          JOIN_STAGE = MIX_LINES;
    localparam int          NUM_STAGES = 2 * MIX_LINES + 1;
    localparam int          LAST_STAGE = NUM_STAGES - 1;
    localparam logic [3:0]  BLOCK_LAST = 4'd11;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    // One subtract/subtract/xor line of the mix, lines 0 to 8 in order.
    function automatic t_abc mix_line(input logic [3:0] idx, input t_abc x);
        t_abc y;
        y = x;
        case (idx)
            4'd0: y.a = (x.a - x.b - x.c) ^ (x.c >> 13);
            4'd1: y.b = (x.b - x.c - x.a) ^ (x.a << 8);
            4'd2: y.c = (x.c - x.a - x.b) ^ (x.b >> 13);
            4'd3: y.a = (x.a - x.b - x.c) ^ (x.c >> 12);
            4'd4: y.b = (x.b - x.c - x.a) ^ (x.a << 16);
            4'd5: y.c = (x.c - x.a - x.b) ^ (x.b >> 5);
            4'd6: y.a = (x.a - x.b - x.c) ^ (x.c >> 3);
            4'd7: y.b = (x.b - x.c - x.a) ^ (x.a << 10);
            4'd8: y.c = (x.c - x.a - x.b) ^ (x.b >> 15);
            default: y = x;
        endcase
        return y;
    endfunction

endpackage

### hdl/jenkins_lookup2_byte_hash.sv
// ----------------------------------------------------------------------------
// jenkins_lookup2_byte_hash
// 32-bit lookup2 hash of a key streamed one byte per item, seeded by a
// configuration register. Block and final mixes run in a 19-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, no stalls other than output back-pressure.
// Stage 0 issues; each mix line is then one pipeline stage (9 for block mix,
// 1 join, then the final mix, whose last line feeds the output register).
// Reset: synchronous, active low; seed clears to 0, pipeline empties, state
// returns to the start-of-key values.
module jenkins_lookup2_byte_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_key_byte,
    input  logic                 i_byte_valid,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_key_hash,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_seed
);
    import jlh_pkg::*;

    // key state
    logic [31:0] r_seed;
    t_abc        r_base,  n_base;
    logic [31:0] r_a_acc, n_a_acc;
    logic [31:0] r_b_acc, n_b_acc;
    logic [23:0] r_c_acc, n_c_acc;
    logic [3:0]  r_pos,   n_pos;
    logic [31:0] r_len,   n_len;

    // pipeline
    logic [NUM_STAGES-1:0] r_vld, n_vld;
    t_abc                  r_abc [NUM_STAGES];
    t_abc                  n_abc [NUM_STAGES];
    logic [JOIN_STAGE:0]   r_blk, n_blk;
    logic [JOIN_STAGE:0]   r_fin, n_fin;
    t_abc                  r_add [JOIN_STAGE+1];
    t_abc                  n_add [JOIN_STAGE+1];

    logic        r_out_valid;
    logic [31:0] r_hash;

    logic        w_adv, w_acc, w_take, w_end, w_blk_done, w_wb, w_inflight, w_cfg_wr;
    logic [31:0] w_len_new;
    t_abc        w_base_eff, w_fin_add, w_last_mix;

    assign o_in_ready   = w_adv;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_key_hash   = r_hash;

    always_comb begin
        w_adv      = !(r_vld[LAST_STAGE] && r_out_valid && !i_out_ready);
        w_acc      = i_in_valid && w_adv;
        w_take     = w_acc && i_byte_valid;
        w_end      = w_acc && i_last;
        w_blk_done = w_take && (r_pos == BLOCK_LAST);
        w_cfg_wr   = i_cfg_valid;
        w_wb       = r_vld[JOIN_STAGE] && r_blk[JOIN_STAGE] && !r_fin[JOIN_STAGE];
        w_base_eff = w_wb ? r_abc[JOIN_STAGE] : r_base;
        w_len_new  = r_len + 32'(w_take);
        w_last_mix = mix_line(4'(MIX_LINES - 1), r_abc[LAST_STAGE]);

        w_inflight = 1'b0;
        for (int i = 0; i < JOIN_STAGE; i++) begin
            w_inflight = w_inflight | (r_vld[i] & r_blk[i] & ~r_fin[i]);
        end

        n_a_acc = r_a_acc;
        n_b_acc = r_b_acc;
        n_c_acc = r_c_acc;
        if (w_take) begin
            case (r_pos[3:2])
                2'd0: n_a_acc[{r_pos[1:0], 3'b000} +: 8] = i_key_byte;
                2'd1: n_b_acc[{r_pos[1:0], 3'b000} +: 8] = i_key_byte;
                2'd2: begin
                    if (r_pos != BLOCK_LAST) begin
                        n_c_acc[{r_pos[1:0], 3'b000} +: 8] = i_key_byte;
                    end
                end
                default: n_c_acc = r_c_acc;
            endcase
        end
        w_fin_add = '{a: n_a_acc, b: n_b_acc, c: w_len_new + {n_c_acc, 8'h00}};

        // key state
        n_base = r_base;
        n_pos  = r_pos;
        n_len  = r_len;
        if (w_end) begin
            n_base  = '{a: GOLDEN, b: GOLDEN, c: r_seed};
            n_a_acc = '0;
            n_b_acc = '0;
            n_c_acc = '0;
            n_pos   = '0;
            n_len   = '0;
        end else begin
            if (w_wb) begin
                n_base = r_abc[JOIN_STAGE];
            end else if (w_cfg_wr && r_len == '0 && r_pos == '0) begin
                n_base.c = i_seed;
            end
            if (w_blk_done) begin
                n_a_acc = '0;
                n_b_acc = '0;
                n_c_acc = '0;
                n_pos   = '0;
            end else if (w_take) begin
                n_pos = r_pos + 4'd1;
            end
            n_len = w_len_new;
        end

        // issue into stage 0
        n_vld[0] = w_blk_done || (w_end && !w_inflight);
        n_blk[0] = w_blk_done;
        n_fin[0] = w_end;
        if (w_blk_done) begin
            n_abc[0] = '{a: w_base_eff.a + r_a_acc,
                         b: w_base_eff.b + r_b_acc,
                         c: w_base_eff.c + {i_key_byte, r_c_acc}};
            n_add[0] = '{a: '0, b: '0, c: w_len_new};
        end else begin
            n_abc[0] = w_base_eff;
            n_add[0] = w_fin_add;
        end

        // block mix, with a late key end folded into the job in flight
        for (int i = 0; i < JOIN_STAGE; i++) begin
            n_vld[i+1] = r_vld[i];
            n_blk[i+1] = r_blk[i];
            n_abc[i+1] = r_blk[i] ? mix_line(4'(i), r_abc[i]) : r_abc[i];
            if (w_end && r_vld[i] && r_blk[i] && !r_fin[i]) begin
                n_fin[i+1] = 1'b1;
                n_add[i+1] = w_fin_add;
            end else begin
                n_fin[i+1] = r_fin[i];
                n_add[i+1] = r_add[i];
            end
        end

        // join: length and tail go in, then the final mix
        n_vld[JOIN_STAGE+1] = r_vld[JOIN_STAGE] && r_fin[JOIN_STAGE];
        n_abc[JOIN_STAGE+1] = '{a: r_abc[JOIN_STAGE].a + r_add[JOIN_STAGE].a,
                                b: r_abc[JOIN_STAGE].b + r_add[JOIN_STAGE].b,
                                c: r_abc[JOIN_STAGE].c + r_add[JOIN_STAGE].c};
        for (int i = JOIN_STAGE + 2; i < NUM_STAGES; i++) begin
            n_vld[i] = r_vld[i-1];
            n_abc[i] = mix_line(4'(i - JOIN_STAGE - 2), r_abc[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_base      <= '{a: GOLDEN, b: GOLDEN, c: 32'h0};
            r_a_acc     <= '0;
            r_b_acc     <= '0;
            r_c_acc     <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_seed <= i_seed;
            end
            r_base  <= n_base;
            r_a_acc <= n_a_acc;
            r_b_acc <= n_b_acc;
            r_c_acc <= n_c_acc;
            r_pos   <= n_pos;
            r_len   <= n_len;
            if (w_adv) begin
                r_vld <= n_vld;
            end
            if (w_adv && r_vld[LAST_STAGE]) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_blk <= n_blk;
            r_fin <= n_fin;
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_abc[i] <= n_abc[i];
            end
            for (int i = 0; i <= JOIN_STAGE; i++) begin
                r_add[i] <= n_add[i];
            end
            if (r_vld[LAST_STAGE]) begin
                r_hash <= w_last_mix.c;
            end
        end
    end

endmodule
